// ===== hw/rtl/wabt_pkg.sv =====
`default_nettype none

package wabt_pkg;

  // Operation codes carried in the func field
  typedef enum logic [1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_ADD    = 2'd1,
    FUNC_REMOVE = 2'd2
  } func_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_PRESENT   = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

  // Control sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_APPLY
  } state_e;

  // Stored pattern: octets in the low 32 bits, wildcard mask on top
  typedef struct packed {
    logic [3:0] wild;
    logic [7:0] oct_d;
    logic [7:0] oct_c;
    logic [7:0] oct_b;
    logic [7:0] oct_a;
  } pattern_t;

  // Request beat
  typedef struct packed {
    logic [1:0] func;
    logic [7:0] octet_a;
    logic [7:0] octet_b;
    logic [7:0] octet_c;
    logic [7:0] octet_d;
    logic [3:0] wild_mask;
  } req_t;

  // Result beat
  typedef struct packed {
    logic [1:0] status;
    logic       hit;
    logic [6:0] position;
    logic [6:0] entry_count;
  } rsp_t;

  // Update command broadcast along the cell row
  typedef struct packed {
    logic append;
    logic remove;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/wabt_cell.sv =====
`default_nettype none

module wabt_cell #(
  parameter int CNT_W = 7,
  parameter int IDX_W = 6,
  parameter int INDEX = 0
) (
  input  wire                      clk_i,
  input  wire wabt_pkg::cell_ctl_t ctl_i,
  input  wire wabt_pkg::pattern_t  query_i,
  input  wire wabt_pkg::pattern_t  next_i,
  input  wire logic [CNT_W-1:0]    count_i,
  input  wire logic [IDX_W-1:0]    pos_i,
  output wabt_pkg::pattern_t       entry_o,
  output logic                     hit_o,
  output logic                     exact_o
);

  localparam logic [CNT_W-1:0] MyCnt   = CNT_W'(INDEX);
  localparam logic [CNT_W-1:0] NextCnt = CNT_W'(INDEX + 1);
  localparam logic [IDX_W-1:0] MyIdx   = IDX_W'(INDEX);

  wabt_pkg::pattern_t entry_q;
  logic               valid;
  logic [3:0]         oct_ok;
  logic [7:0]         e_oct [4];
  logic [7:0]         q_oct [4];

  assign valid = (MyCnt < count_i);

  assign e_oct[0] = entry_q.oct_a;
  assign e_oct[1] = entry_q.oct_b;
  assign e_oct[2] = entry_q.oct_c;
  assign e_oct[3] = entry_q.oct_d;
  assign q_oct[0] = query_i.oct_a;
  assign q_oct[1] = query_i.oct_b;
  assign q_oct[2] = query_i.oct_c;
  assign q_oct[3] = query_i.oct_d;

  // Per octet: entry wildcard, or concrete query octet equal to entry octet
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      oct_ok[k] = entry_q.wild[k] | (~query_i.wild[k] & (e_oct[k] == q_oct[k]));
    end
  end

  assign hit_o   = valid & (&oct_ok);
  assign exact_o = valid & (entry_q == query_i);
  assign entry_o = entry_q;

  // Load the new pattern on append, or pull the neighbor's entry on remove
  always_ff @(posedge clk_i) begin
    if (ctl_i.append && (count_i == MyCnt)) begin
      entry_q <= query_i;
    end else if (ctl_i.remove && (MyIdx >= pos_i) && (NextCnt < count_i)) begin
      entry_q <= next_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/wabt_tree.sv =====
`default_nettype none

module wabt_tree #(
  parameter int LEAVES = 64
) (
  input  wire                              clk_i,
  input  wire logic [LEAVES-1:0]           hit_i,
  input  wire logic [LEAVES-1:0]           exact_i,
  output logic                             hit_o,
  output logic                             found_o,
  output logic [$clog2(LEAVES)-1:0]        pos_o
);

  localparam int Depth = $clog2(LEAVES);
  localparam int Pad   = 1 << Depth;
  localparam int IdxW  = Depth;

  // Heap-ordered nodes: root at 1, leaves at Pad .. 2*Pad-1
  logic            hit_q   [1:2*Pad-1];
  logic            found_q [1:2*Pad-1];
  logic [IdxW-1:0] pos_q   [1:2*Pad-1];

  // Register the leaves; padding leaves stay empty
  for (genvar j = 0; j < Pad; j++) begin : g_leaf
    if (j < LEAVES) begin : g_real
      always_ff @(posedge clk_i) begin
        hit_q[Pad+j]   <= hit_i[j];
        found_q[Pad+j] <= exact_i[j];
        pos_q[Pad+j]   <= exact_i[j] ? IdxW'(j) : '0;
      end
    end else begin : g_pad
      always_ff @(posedge clk_i) begin
        hit_q[Pad+j]   <= 1'b0;
        found_q[Pad+j] <= 1'b0;
        pos_q[Pad+j]   <= '0;
      end
    end
  end

  // Merge pairs one level per cycle; at most one exact entry exists
  for (genvar n = 1; n < Pad; n++) begin : g_node
    always_ff @(posedge clk_i) begin
      hit_q[n]   <= hit_q[2*n] | hit_q[2*n+1];
      found_q[n] <= found_q[2*n] | found_q[2*n+1];
      pos_q[n]   <= pos_q[2*n] | pos_q[2*n+1];
    end
  end

  assign hit_o   = hit_q[1];
  assign found_o = found_q[1];
  assign pos_o   = pos_q[1];

endmodule

`default_nettype wire

// ===== hw/rtl/wildcard_address_ban_table.sv =====
`default_nettype none

// Wildcard IPv4 ban table. Each request (lookup, add or remove) is taken
// when start is high and busy is low, and yields exactly one result beat on
// rsp_o, flagged by done_o for a single cycle; the receiver cannot stall it.
// Every table entry sits in its own cell and is compared against the query
// in parallel; the match flags are then merged by a registered OR tree of
// D = clog2(TABLE_ENTRIES) levels. A request holds busy high through the
// search and apply states, so no new request is taken before it is applied;
// the tree depth sets how long the search lasts. No clearing pass is needed
// after reset.
module wildcard_address_ban_table #(
  parameter int TABLE_ENTRIES = 64
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start,
  output logic                busy,
  input  wire wabt_pkg::req_t req_i,
  output logic                done_o,
  output wabt_pkg::rsp_t      rsp_o
);

  localparam int Depth = $clog2(TABLE_ENTRIES);
  localparam int IdxW  = Depth;
  localparam int CntW  = $clog2(TABLE_ENTRIES + 1);
  localparam int WaitW = $clog2(Depth + 1);
  localparam int WideW = (CntW > 7) ? CntW : 7;
  localparam logic [CntW-1:0]  Full     = CntW'(TABLE_ENTRIES);
  localparam logic [WaitW-1:0] WaitLast = WaitW'(Depth);

  wabt_pkg::state_e   state_q, state_d;
  logic [WaitW-1:0]   wait_q;
  logic [CntW-1:0]    count_q, count_d;
  wabt_pkg::pattern_t query_q, query_d;
  logic [1:0]         func_q;
  logic               accept;
  logic               apply;

  wabt_pkg::pattern_t      entries [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] cell_hit;
  logic [TABLE_ENTRIES-1:0] cell_exact;
  wabt_pkg::cell_ctl_t     cell_ctl;

  logic               root_hit;
  logic               root_found;
  logic [IdxW-1:0]    root_pos;

  wabt_pkg::rsp_t     rsp_d, rsp_q;
  logic               done_q;
  logic [WideW-1:0]   pos_wide;
  logic [WideW-1:0]   cnt_wide;

  assign accept = start & ~busy;

  // Build the query pattern: octets under a wildcard bit read as zero
  always_comb begin
    query_d.wild  = req_i.wild_mask;
    query_d.oct_a = req_i.wild_mask[0] ? 8'd0 : req_i.octet_a;
    query_d.oct_b = req_i.wild_mask[1] ? 8'd0 : req_i.octet_b;
    query_d.oct_c = req_i.wild_mask[2] ? 8'd0 : req_i.octet_c;
    query_d.oct_d = req_i.wild_mask[3] ? 8'd0 : req_i.octet_d;
  end

  // Hold the accepted request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      query_q <= query_d;
      func_q  <= req_i.func;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      wabt_pkg::S_IDLE: begin
        if (start) state_d = wabt_pkg::S_SEARCH;
      end
      wabt_pkg::S_SEARCH: begin
        if (wait_q == WaitLast) state_d = wabt_pkg::S_APPLY;
      end
      wabt_pkg::S_APPLY: begin
        state_d = wabt_pkg::S_IDLE;
      end
      default: begin
        state_d = wabt_pkg::S_IDLE;
      end
    endcase
  end

  // State outputs
  always_comb begin
    busy  = 1'b1;
    apply = 1'b0;
    case (state_q)
      wabt_pkg::S_IDLE:   busy  = 1'b0;
      wabt_pkg::S_SEARCH: apply = 1'b0;
      wabt_pkg::S_APPLY:  apply = 1'b1;
      default:            busy  = 1'b1;
    endcase
  end

  // Advance state and the tree wait counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wabt_pkg::S_IDLE;
      wait_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == wabt_pkg::S_SEARCH) begin
        wait_q <= wait_q + WaitW'(1);
      end else begin
        wait_q <= '0;
      end
    end
  end

  // Decide the table update and the result from the tree root
  always_comb begin
    cell_ctl.append = 1'b0;
    cell_ctl.remove = 1'b0;
    count_d         = count_q;
    rsp_d.status    = wabt_pkg::STAT_DONE;
    rsp_d.hit       = 1'b0;
    case (func_q)
      wabt_pkg::FUNC_ADD: begin
        if (root_found) begin
          rsp_d.status = wabt_pkg::STAT_PRESENT;
          rsp_d.hit    = 1'b1;
        end else if (count_q >= Full) begin
          rsp_d.status = wabt_pkg::STAT_FULL;
        end else begin
          cell_ctl.append = apply;
          count_d         = count_q + CntW'(1);
        end
      end
      wabt_pkg::FUNC_REMOVE: begin
        if (root_found) begin
          rsp_d.hit       = 1'b1;
          cell_ctl.remove = apply;
          count_d         = count_q - CntW'(1);
        end else begin
          rsp_d.status = wabt_pkg::STAT_NOT_FOUND;
        end
      end
      default: begin
        rsp_d.hit = root_hit;
      end
    endcase
    pos_wide          = root_found ? WideW'(CntW'(root_pos)) : WideW'(count_q);
    cnt_wide          = WideW'(count_d);
    rsp_d.position    = pos_wide[6:0];
    rsp_d.entry_count = cnt_wide[6:0];
  end

  // Commit the entry count and drive the result beat for one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= apply;
      if (apply) count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (apply) rsp_q <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // Row of entry cells, each pulling from its upper neighbor on remove
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    wabt_pkg::pattern_t next_entry;
    if (i == TABLE_ENTRIES - 1) begin : g_last
      assign next_entry = entries[i];
    end else begin : g_mid
      assign next_entry = entries[i+1];
    end

    wabt_cell #(
      .CNT_W (CntW),
      .IDX_W (IdxW),
      .INDEX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (cell_ctl),
      .query_i (query_q),
      .next_i  (next_entry),
      .count_i (count_q),
      .pos_i   (root_pos),
      .entry_o (entries[i]),
      .hit_o   (cell_hit[i]),
      .exact_o (cell_exact[i])
    );
  end

  // Merge the cell flags
  wabt_tree #(
    .LEAVES (TABLE_ENTRIES)
  ) u_tree (
    .clk_i   (clk_i),
    .hit_i   (cell_hit),
    .exact_i (cell_exact),
    .hit_o   (root_hit),
    .found_o (root_found),
    .pos_o   (root_pos)
  );

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import wabt_pkg::*;

  localparam int TABLE_ENTRIES = 64;
  localparam int RANDOM_ITEMS  = 1830;
  localparam int STALL_LIMIT   = 400;
  localparam int DRAIN_CYCLES  = 16;
  localparam int REPORT_LIMIT  = 10;

  // The fourth selector code has no name in the package; it acts as a lookup
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  typedef struct {
    req_t req;
    bit   fixed;
    rsp_t want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_beat;
  logic done_beat;
  rsp_t rsp_beat;

  // Shadow copy of the ban table
  pattern_t ban_store [TABLE_ENTRIES];
  int       ban_count;

  rsp_t      pending_results[$];
  stim_row_t directed_rows[$];
  int        mismatches;
  int        stall_cycles;
  bit        filling;

  wildcard_address_ban_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_beat),
    .done_o(done_beat),
    .rsp_o (rsp_beat)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Apply one request to the shadow table and return the result it should give
  function automatic rsp_t ban_table_apply(input req_t r);
    pattern_t pat;
    rsp_t     res;
    int       prior_count;
    int       idx;
    logic     found;
    logic     ok;
    pat.wild  = r.wild_mask;
    pat.oct_a = r.wild_mask[0] ? 8'd0 : r.octet_a;
    pat.oct_b = r.wild_mask[1] ? 8'd0 : r.octet_b;
    pat.oct_c = r.wild_mask[2] ? 8'd0 : r.octet_c;
    pat.oct_d = r.wild_mask[3] ? 8'd0 : r.octet_d;
    prior_count = ban_count;
    idx = prior_count;
    for (int k = prior_count - 1; k >= 0; k--) begin
      if (ban_store[k] == pat) idx = k;
    end
    found = (idx < prior_count);
    res = '0;
    res.status = STAT_DONE;
    case (r.func)
      FUNC_ADD: begin
        if (found) begin
          res.status = STAT_PRESENT;
          res.hit = 1'b1;
        end else if (prior_count >= TABLE_ENTRIES) begin
          res.status = STAT_FULL;
        end else begin
          ban_store[prior_count] = pat;
          ban_count = prior_count + 1;
        end
      end
      FUNC_REMOVE: begin
        if (found) begin
          res.hit = 1'b1;
          // shift later entries down over the removed one
          for (int k = idx; k < prior_count - 1; k++) ban_store[k] = ban_store[k + 1];
          ban_count = prior_count - 1;
        end else begin
          res.status = STAT_NOT_FOUND;
        end
      end
      default: begin
        // an entry octet matches if it is wild, or the query gives the same value
        for (int k = 0; k < prior_count; k++) begin
          ok = 1'b1;
          for (int o = 0; o < 4; o++) begin
            if (!ban_store[k].wild[o] &&
                (pat.wild[o] || ban_store[k][8*o +: 8] != pat[8*o +: 8])) ok = 1'b0;
          end
          if (ok) res.hit = 1'b1;
        end
      end
    endcase
    res.position    = idx[6:0];
    res.entry_count = ban_count[6:0];
    return res;
  endfunction

  function automatic logic [7:0] draw_octet();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'($urandom_range(0, 3));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Bias toward adds while filling and removes while draining; reuse stored
  // patterns half the time so present, remove and lookup hits are common
  function automatic req_t draw_request();
    req_t     r;
    pattern_t p;
    int       roll;
    roll = $urandom_range(0, 99);
    if (filling) begin
      if (roll < 70) r.func = FUNC_ADD;
      else if (roll < 85) r.func = FUNC_LOOKUP;
      else if (roll < 95) r.func = FUNC_REMOVE;
      else r.func = FUNC_SPARE;
    end else begin
      if (roll < 15) r.func = FUNC_ADD;
      else if (roll < 30) r.func = FUNC_LOOKUP;
      else if (roll < 95) r.func = FUNC_REMOVE;
      else r.func = FUNC_SPARE;
    end
    r.octet_a = draw_octet();
    r.octet_b = draw_octet();
    r.octet_c = draw_octet();
    r.octet_d = draw_octet();
    r.wild_mask = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 15)) : 4'h0;
    if (ban_count > 0 && $urandom_range(0, 1) == 1) begin
      p = ban_store[$urandom_range(0, ban_count - 1)];
      r.wild_mask = p.wild;
      if (!p.wild[0]) r.octet_a = p.oct_a;
      if (!p.wild[1]) r.octet_b = p.oct_b;
      if (!p.wild[2]) r.octet_c = p.oct_c;
      if (!p.wild[3]) r.octet_d = p.oct_d;
      // perturb the mask of some queries so near misses show up
      if (r.func != FUNC_ADD && r.func != FUNC_REMOVE && $urandom_range(0, 3) == 0)
        r.wild_mask = r.wild_mask ^ 4'($urandom_range(1, 15));
    end
    return r;
  endfunction

  task automatic add_row(input logic [1:0] func, input logic [7:0] a, input logic [7:0] b,
                         input logic [7:0] c, input logic [7:0] d, input logic [3:0] mask,
                         input bit fixed, input status_e st, input logic hit,
                         input int pos, input int cnt);
    stim_row_t row;
    row.req.func        = func;
    row.req.octet_a     = a;
    row.req.octet_b     = b;
    row.req.octet_c     = c;
    row.req.octet_d     = d;
    row.req.wild_mask   = mask;
    row.fixed           = fixed;
    row.want.status     = st;
    row.want.hit        = hit;
    row.want.position   = 7'(pos);
    row.want.entry_count = 7'(cnt);
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // Hold off for gap cycles, present the beat, and wait for it to be taken
  task automatic send_beat(input req_t r, input int gap, input bit fixed, input rsp_t want);
    rsp_t predicted;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start    <= 1'b1;
    req_beat <= r;
    do @(posedge clk_i); while (busy);
    predicted = ban_table_apply(r);
    pending_results.insert(pending_results.size(), fixed ? want : predicted);
  endtask

  task automatic flag_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
  endtask

  // Compare each result beat against the oldest pending expectation
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && done_beat === 1'b1) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result beats pending", 0, 1);
      end else begin
        want = pending_results.pop_front();
        if (rsp_beat.status !== want.status)
          flag_mismatch("status", want.status, rsp_beat.status);
        if (rsp_beat.hit !== want.hit)
          flag_mismatch("hit", want.hit, rsp_beat.hit);
        if (rsp_beat.position !== want.position)
          flag_mismatch("position", want.position, rsp_beat.position);
        if (rsp_beat.entry_count !== want.entry_count)
          flag_mismatch("entry_count", want.entry_count, rsp_beat.entry_count);
      end
    end
  end

  // Abort if nothing is accepted or returned for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_beat === 1'b1) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    bit   quiet;
    int   gap;
    rsp_t none;
    rst_ni     = 1'b0;
    start      = 1'b0;
    req_beat   = '0;
    ban_count  = 0;
    mismatches = 0;
    filling    = 1'b1;
    quiet      = 1'b0;
    none       = '0;

    // Directed rows: empty table, extremes, wildcard rules, shifting removes
    add_row(FUNC_LOOKUP, 8'd0,   8'd0,   8'd0,   8'd0,   4'b0000, 1, STAT_DONE,      0, 0, 0);
    add_row(FUNC_REMOVE, 8'd0,   8'd0,   8'd0,   8'd0,   4'b0000, 1, STAT_NOT_FOUND, 0, 0, 0);
    add_row(FUNC_ADD,    8'd0,   8'd0,   8'd0,   8'd0,   4'b0000, 1, STAT_DONE,      0, 0, 1);
    add_row(FUNC_ADD,    8'd255, 8'd255, 8'd255, 8'd255, 4'b0000, 1, STAT_DONE,      0, 1, 2);
    add_row(FUNC_ADD,    8'd255, 8'd255, 8'd255, 8'd255, 4'b0000, 1, STAT_PRESENT,   1, 1, 2);
    add_row(FUNC_LOOKUP, 8'd255, 8'd255, 8'd255, 8'd255, 4'b0000, 1, STAT_DONE,      1, 1, 2);
    add_row(FUNC_ADD,    8'd10,  8'd77,  8'd88,  8'd99,  4'b1110, 1, STAT_DONE,      0, 2, 3);
    // octets under a wildcard are ignored, so this is the same pattern
    add_row(FUNC_ADD,    8'd10,  8'd1,   8'd2,   8'd3,   4'b1110, 1, STAT_PRESENT,   1, 2, 3);
    add_row(FUNC_LOOKUP, 8'd10,  8'd1,   8'd2,   8'd3,   4'b0000, 1, STAT_DONE,      1, 3, 3);
    // a wild query octet never matches a concrete entry octet
    add_row(FUNC_LOOKUP, 8'd0,   8'd0,   8'd0,   8'd0,   4'b0001, 1, STAT_DONE,      0, 3, 3);
    add_row(FUNC_LOOKUP, 8'd11,  8'd1,   8'd2,   8'd3,   4'b0000, 1, STAT_DONE,      0, 3, 3);
    add_row(FUNC_ADD,    8'd170, 8'd85,  8'd170, 8'd85,  4'b1111, 1, STAT_DONE,      0, 3, 4);
    add_row(FUNC_LOOKUP, 8'd1,   8'd2,   8'd3,   8'd4,   4'b1111, 1, STAT_DONE,      1, 3, 4);
    add_row(FUNC_SPARE,  8'd1,   8'd2,   8'd3,   8'd4,   4'b0000, 0, STAT_DONE,      0, 0, 0);
    add_row(FUNC_REMOVE, 8'd0,   8'd0,   8'd0,   8'd0,   4'b0000, 1, STAT_DONE,      1, 0, 3);
    add_row(FUNC_REMOVE, 8'd0,   8'd0,   8'd0,   8'd0,   4'b0000, 1, STAT_NOT_FOUND, 0, 3, 3);
    add_row(FUNC_LOOKUP, 8'd255, 8'd255, 8'd255, 8'd255, 4'b0000, 1, STAT_DONE,      1, 0, 3);
    add_row(FUNC_REMOVE, 8'd85,  8'd170, 8'd85,  8'd170, 4'b1111, 1, STAT_DONE,      1, 2, 2);
    add_row(FUNC_LOOKUP, 8'd1,   8'd2,   8'd3,   8'd4,   4'b0000, 1, STAT_DONE,      0, 2, 2);
    add_row(FUNC_ADD,    8'd10,  8'd5,   8'd5,   8'd5,   4'b1100, 0, STAT_DONE,      0, 0, 0);
    add_row(FUNC_LOOKUP, 8'd10,  8'd5,   8'd6,   8'd7,   4'b0000, 0, STAT_DONE,      0, 0, 0);
    add_row(FUNC_REMOVE, 8'd255, 8'd255, 8'd255, 8'd255, 4'b0000, 0, STAT_DONE,      0, 0, 0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].req, $urandom_range(0, 3), directed_rows[i].fixed,
                directed_rows[i].want);
    end

    // Random part: alternate fill and drain sweeps across the whole table
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (ban_count == 0) filling = 1'b1;
      else if (ban_count == TABLE_ENTRIES && $urandom_range(0, 7) == 0) filling = 1'b0;
      // drain everything in flight now and then
      if (n == RANDOM_ITEMS / 3 || $urandom_range(0, 99) == 0) begin
        start <= 1'b0;
        @(posedge clk_i);
        while (pending_results.size() != 0) @(posedge clk_i);
      end
      if ($urandom_range(0, 31) == 0) quiet = !quiet;
      gap = quiet ? 0 : $urandom_range(0, 3);
      send_beat(draw_request(), gap, 1'b0, none);
    end

    // Let the last beats come back
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/wabt_pkg.sv
hw/rtl/wabt_cell.sv
hw/rtl/wabt_tree.sv
hw/rtl/wildcard_address_ban_table.sv
tb/sv/testbench.sv
